FILE: hw/rtl/jfdq_pkg.sv
// Package with the constants and tables of the JPEG forward DCT quantizer.
`default_nettype none
package jfdq_pkg;
    typedef logic signed [25:0] dword_t;

    localparam logic signed [15:0] K_A1 = 16'sd11585;
    localparam logic signed [15:0] K_A2 = -16'sd8867;
    localparam logic signed [15:0] K_A4 = 16'sd21407;
    localparam logic signed [15:0] K_A5 = 16'sd6270;

    localparam logic signed [22:0] DC_SHIFT = 23'sd131072;
    localparam logic [10:0] DC_LIMIT = 11'd2047;
    localparam logic [10:0] AC_LIMIT = 11'd1023;

    localparam logic [0:0] OP_LOAD  = 1'b0;
    localparam logic [0:0] OP_PIXEL = 1'b1;

    // b[0] = 1/(2 sqrt 2), b[i] = 1/(4 cos(i pi/16)) for i = 1..7, 16 fraction bits.
    localparam logic [16:0] B_VEC [8] = '{
        17'd23170, 17'd16705, 17'd17734, 17'd19705,
        17'd23170, 17'd29490, 17'd42813, 17'd83982
    };

    localparam logic [5:0] ZZ_TO_NAT [64] = '{
         0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
        12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
        35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
        58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
    };
endpackage
`default_nettype wire

FILE: hw/rtl/jfdq_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none
module jfdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/jpeg_forward_dct_quantizer_top.sv
// Top level of the JPEG 8x8 forward DCT with quantization.
//
//   channel | direction | ports                                          | handshake
//   s_      | in        | s_op, s_position, s_value                      | s_valid/s_ready
//   m_      | out       | m_coefficient, m_zigzag_index, m_last, m_status| m_valid/m_ready
//
// A pixel item is written into the pixel memory. A nonzero quantizer load runs the
// 18-step restoring divider; every load gives one acknowledgement item. The 64th
// pixel starts the transform: 16 line passes (8 memory reads, 5 products on the one
// shared multiplier, 8 writes), then the quantizer steps QRD, QMUL and QOUT per
// coefficient. Reset clears the control state only; the pixel and transform
// memories are read only after written. The user must load the scale memory before
// a block; the block does not enforce it. A stalled output holds the block in its
// current step; no input is taken then.
`default_nettype none
module jpeg_forward_dct_quantizer_top
    import jfdq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_op,
    input  wire logic [5:0]         s_position,
    input  wire logic [7:0]         s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [11:0]      m_coefficient,
    output logic [5:0]              m_zigzag_index,
    output logic                    m_last,
    output logic                    m_status
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_LMUL, ST_LPRE, ST_LDIV, ST_LWR, ST_LACK,
        ST_DRD, ST_DMUL, ST_DWR, ST_QRD, ST_QMUL, ST_QOUT
    } state_t;

    state_t              state_reg;
    logic [5:0]          count_reg;
    logic [4:0]          cnt_reg;
    logic [2:0]          line_reg;
    logic                pass_reg;
    logic [5:0]          qi_reg;
    logic [5:0]          lpos_reg;
    logic [7:0]          lq_reg;
    logic                lst_reg;
    logic [33:0]         lprod_reg;
    logic [17:0]         dq_reg;
    logic [7:0]          rem_reg;
    logic signed [21:0]  x_reg [8];
    dword_t              k_reg [5];
    logic [40:0]         qprod_reg;
    logic                qneg_reg;
    logic                qdc_reg;

    logic                m_valid_reg;
    logic signed [11:0]  m_coef_reg;
    logic [5:0]          m_idx_reg;
    logic                m_last_reg;
    logic                m_status_reg;

    logic out_free;
    logic out_load;
    logic accept;
    assign out_free = !m_valid_reg || m_ready;
    // A new result item is loaded into the output register in this cycle.
    assign out_load = ((state_reg == ST_LACK) || (state_reg == ST_QOUT)) && out_free;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;

    // Memories.
    logic        pix_we;
    logic [5:0]  pix_addr;
    logic [7:0]  pix_rdata;
    logic        tb_we;
    logic [5:0]  tb_addr;
    logic [21:0] tb_wdata;
    logic [21:0] tb_rdata;
    logic        sc_we;
    logic [5:0]  sc_addr;
    logic [17:0] sc_rdata;
    logic [5:0]  ld_nat;
    logic [5:0]  q_nat;
    logic [5:0]  line_addr;

    assign ld_nat    = ZZ_TO_NAT[lpos_reg];
    assign q_nat     = ZZ_TO_NAT[qi_reg];
    assign line_addr = pass_reg ? {cnt_reg[2:0], line_reg} : {line_reg, cnt_reg[2:0]};

    always_comb begin
        pix_we   = accept && (s_op == OP_PIXEL);
        pix_addr = pix_we ? count_reg : line_addr;
        tb_we    = (state_reg == ST_DWR);
        tb_addr  = (state_reg == ST_QRD) ? q_nat : line_addr;
        sc_we    = (state_reg == ST_LWR);
        sc_addr  = sc_we ? ld_nat : q_nat;
    end

    jfdq_ram #(.WIDTH(8), .DEPTH(64)) u_pix_ram (
        .aclk(aclk), .we(pix_we), .addr(pix_addr), .wdata(s_value), .rdata(pix_rdata)
    );
    jfdq_ram #(.WIDTH(22), .DEPTH(64)) u_tb_ram (
        .aclk(aclk), .we(tb_we), .addr(tb_addr), .wdata(tb_wdata), .rdata(tb_rdata)
    );
    jfdq_ram #(.WIDTH(18), .DEPTH(64)) u_sc_ram (
        .aclk(aclk), .we(sc_we), .addr(sc_addr), .wdata(dq_reg), .rdata(sc_rdata)
    );

    // Butterflies of the 8-point AAN transform on the loaded line.
    dword_t xe [8];
    dword_t t0, t1, t2, t3, t4, t5, t6, t7;
    dword_t s0, s1, s2b, s3, s4, s5, s6;
    dword_t p2, p4, p5, p6, u5, u7;
    dword_t y [8];
    dword_t mul_op;
    logic signed [15:0] mul_k;
    logic signed [41:0] mul_full;
    dword_t kres;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            xe[i] = 26'(x_reg[i]);
        end
        t0 = xe[0] + xe[7];
        t1 = xe[1] + xe[6];
        t2 = xe[5] + xe[2];
        t3 = xe[3] + xe[4];
        t4 = xe[3] - xe[4];
        t5 = xe[2] - xe[5];
        t6 = xe[1] - xe[6];
        t7 = xe[0] - xe[7];
        s0 = t0 + t3;
        s1 = t1 + t2;
        s3 = t0 - t3;
        s2b = (t1 - t2) + s3;
        s4 = -t4 - t5;
        s5 = t5 + t6;
        s6 = t6 + t7;

        case (cnt_reg[2:0])
            3'd0: begin mul_op = s6 + s4; mul_k = K_A5; end
            3'd1: begin mul_op = s2b;     mul_k = K_A1; end
            3'd2: begin mul_op = s4;      mul_k = K_A2; end
            3'd3: begin mul_op = s5;      mul_k = K_A1; end
            default: begin mul_op = s6;   mul_k = K_A4; end
        endcase
        mul_full = 42'(mul_op) * 42'(mul_k);
        kres     = 26'((mul_full + 42'sd8192) >>> 14);

        p2 = k_reg[1];
        p4 = k_reg[2] - k_reg[0];
        p5 = k_reg[3];
        p6 = k_reg[4] - k_reg[0];
        u5 = p5 + t7;
        u7 = t7 - p5;
        y[0] = s0 + s1;
        y[4] = s0 - s1;
        y[2] = p2 + s3;
        y[6] = s3 - p2;
        y[5] = p4 + u7;
        y[1] = u5 + p6;
        y[7] = u5 - p6;
        y[3] = u7 - p4;
        tb_wdata = 22'(y[cnt_reg[2:0]]);
    end

    // Divider step and quantizer arithmetic.
    logic [8:0]          div_shift;
    logic                div_ge;
    logic signed [22:0]  qt;
    logic [22:0]         qmag;
    logic [21:0]         qround;
    logic [10:0]         qlim;
    logic [10:0]         qclamp;
    logic [33:0]         lnum;

    always_comb begin
        div_shift = {rem_reg, dq_reg[17]};
        div_ge    = (div_shift >= {1'b0, lq_reg});
        lnum      = lprod_reg + {11'd0, lq_reg, 15'd0};

        qt   = 23'(signed'(tb_rdata));
        if (q_nat == 6'd0) begin
            qt = qt - DC_SHIFT;
        end
        qmag = qt[22] ? 23'(-qt) : 23'(qt);

        qround = 22'((qprod_reg + 41'd524288) >> 20);
        qlim   = qdc_reg ? DC_LIMIT : AC_LIMIT;
        qclamp = (qround > {11'd0, qlim}) ? qlim : qround[10:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cnt_reg     <= '0;
            line_reg    <= '0;
            pass_reg    <= 1'b0;
            qi_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_op == OP_LOAD) begin
                            lpos_reg  <= s_position;
                            lq_reg    <= s_value;
                            lst_reg   <= (s_value == 8'd0);
                            state_reg <= (s_value == 8'd0) ? ST_LACK : ST_LMUL;
                        end else begin
                            count_reg <= count_reg + 6'd1;
                            if (count_reg == 6'd63) begin
                                pass_reg  <= 1'b0;
                                line_reg  <= '0;
                                cnt_reg   <= '0;
                                state_reg <= ST_DRD;
                            end
                        end
                    end
                end
                ST_LMUL: begin
                    lprod_reg <= {17'd0, B_VEC[ld_nat[5:3]]} * {17'd0, B_VEC[ld_nat[2:0]]};
                    state_reg <= ST_LPRE;
                end
                ST_LPRE: begin
                    dq_reg    <= lnum[33:16];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_LDIV;
                end
                ST_LDIV: begin
                    rem_reg <= div_ge ? 8'(div_shift - {1'b0, lq_reg}) : div_shift[7:0];
                    dq_reg  <= {dq_reg[16:0], div_ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd17) begin
                        state_reg <= ST_LWR;
                    end
                end
                ST_LWR: begin
                    state_reg <= ST_LACK;
                end
                ST_LACK: begin
                    if (out_free) begin
                        m_coef_reg   <= '0;
                        m_idx_reg    <= lpos_reg;
                        m_last_reg   <= 1'b0;
                        m_status_reg <= lst_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_DRD: begin
                    if (cnt_reg != 5'd0) begin
                        x_reg[3'(cnt_reg - 5'd1)] <= pass_reg ? signed'(tb_rdata)
                                                              : signed'({10'd0, pix_rdata, 4'd0});
                    end
                    if (cnt_reg == 5'd8) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DMUL;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_DMUL: begin
                    k_reg[3'(cnt_reg)] <= kres;
                    if (cnt_reg == 5'd4) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DWR;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_DWR: begin
                    if (cnt_reg == 5'd7) begin
                        cnt_reg  <= '0;
                        line_reg <= line_reg + 3'd1;
                        if (line_reg == 3'd7) begin
                            if (pass_reg) begin
                                qi_reg    <= '0;
                                state_reg <= ST_QRD;
                            end else begin
                                pass_reg  <= 1'b1;
                                state_reg <= ST_DRD;
                            end
                        end else begin
                            state_reg <= ST_DRD;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_QRD: begin
                    state_reg <= ST_QMUL;
                end
                ST_QMUL: begin
                    qprod_reg <= {18'd0, qmag} * {23'd0, sc_rdata};
                    qneg_reg  <= qt[22];
                    qdc_reg   <= (q_nat == 6'd0);
                    state_reg <= ST_QOUT;
                end
                ST_QOUT: begin
                    if (out_free) begin
                        m_coef_reg   <= qneg_reg ? -12'(qclamp) : 12'(qclamp);
                        m_idx_reg    <= qi_reg;
                        m_last_reg   <= (qi_reg == 6'd63);
                        m_status_reg <= 1'b0;
                        qi_reg       <= qi_reg + 6'd1;
                        state_reg    <= (qi_reg == 6'd63) ? ST_IDLE : ST_QRD;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_coefficient  = m_coef_reg;
    assign m_zigzag_index = m_idx_reg;
    assign m_last         = m_last_reg;
    assign m_status       = m_status_reg;

    // The final coefficient of a block always sits at zigzag position 63.
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_zigzag_index == 6'd63)
        else $error("last item not at zigzag position 63");

    // A rejected load is acknowledged with a zero coefficient and no last flag.
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_coefficient == 12'sd0 && !m_last)
        else $error("rejected load carries coefficient data");

    // A coefficient never takes the value -2048, which lies outside the clamped range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_coefficient != -12'sd2048)
        else $error("coefficient outside clamp range");
endmodule
`default_nettype wire
